// ===== rtl/grc_pkg.sv =====
`default_nettype none

package grc_pkg;

    localparam int MAP_WIDTH      = 32;
    localparam int MAP_HEIGHT     = 32;
    localparam int SCREEN_COLUMNS = 48;

    localparam int MAP_ADDR_W = 10;
    localparam int MAP_DEPTH  = 1 << MAP_ADDR_W;

    localparam int ANGLE_SPAN   = 60;
    localparam int ANGLE_BIAS   = 330;
    localparam int FULL_TURN    = 360;
    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN    = 180;
    localparam int THREE_QUART  = 270;

    // degrees per screen column with two fraction bits
    localparam int COL_STEP_Q2 = (ANGLE_SPAN * 4) / SCREEN_COLUMNS;

    localparam int WALL_SCALE = 30720;
    localparam int DIV_BITS   = 15;
    localparam int MAX_SPAN   = 38;
    localparam int ROW_CENTRE = 20;

    localparam int STEP_RESET  = 20;
    localparam int RANGE_RESET = 12288;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_CAST = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_STEP_LENGTH = 1'b0,
        REG_RANGE_LIMIT = 1'b1
    } t_reg_idx;

    localparam logic [10:0] QSIN [0:90] = '{
        11'd0, 11'd18, 11'd36, 11'd54, 11'd71, 11'd89, 11'd107, 11'd125, 11'd143, 11'd160,
        11'd178, 11'd195, 11'd213, 11'd230, 11'd248, 11'd265, 11'd282, 11'd299, 11'd316,
        11'd333, 11'd350, 11'd367, 11'd384, 11'd400, 11'd416, 11'd433, 11'd449, 11'd465,
        11'd481, 11'd496, 11'd512, 11'd527, 11'd543, 11'd558, 11'd573, 11'd587, 11'd602,
        11'd616, 11'd630, 11'd644, 11'd658, 11'd672, 11'd685, 11'd698, 11'd711, 11'd724,
        11'd737, 11'd749, 11'd761, 11'd773, 11'd784, 11'd796, 11'd807, 11'd818, 11'd828,
        11'd839, 11'd849, 11'd859, 11'd868, 11'd878, 11'd887, 11'd896, 11'd904, 11'd912,
        11'd920, 11'd928, 11'd935, 11'd943, 11'd949, 11'd956, 11'd962, 11'd968, 11'd974,
        11'd979, 11'd984, 11'd989, 11'd994, 11'd998, 11'd1002, 11'd1005, 11'd1008, 11'd1011,
        11'd1014, 11'd1016, 11'd1018, 11'd1020, 11'd1022, 11'd1023, 11'd1023, 11'd1024,
        11'd1024
    };

    // a is already reduced to 0..359
    function automatic logic signed [11:0] rom_sin(input logic [8:0] a);
        logic [6:0]  idx;
        logic        neg;
        logic [11:0] mag;
        if (a <= 9'(QUARTER_TURN)) begin
            idx = 7'(a);
            neg = 1'b0;
        end else if (a <= 9'(HALF_TURN)) begin
            idx = 7'(9'(HALF_TURN) - a);
            neg = 1'b0;
        end else if (a <= 9'(THREE_QUART)) begin
            idx = 7'(a - 9'(HALF_TURN));
            neg = 1'b1;
        end else begin
            idx = 7'(9'(FULL_TURN) - a);
            neg = 1'b1;
        end
        mag = {1'b0, QSIN[idx]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [12:0] col_offset(input logic [5:0] col);
        return 13'((13'(col) * 13'(COL_STEP_Q2)) >> 2);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/grc_map.sv =====
`default_nettype none

module grc_map
    import grc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [MAP_ADDR_W-1:0] i_waddr,
    input  wire logic                  i_wdata,
    input  wire logic [MAP_ADDR_W-1:0] i_raddr,
    output logic                       o_rdata
);

    logic r_mem [0:MAP_DEPTH-1];
    logic r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/grc_div.sv =====
`default_nettype none

// restoring divide of the constant wall scale, one quotient bit per cycle
module grc_div
    import grc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [16:0]         i_divisor,
    output logic                     o_done,
    output logic [DIV_BITS-1:0]      o_quot
);

    localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(WALL_SCALE);
    localparam int CNT_W = $clog2(DIV_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [16:0]         r_den;
    logic [16:0]         r_rem;
    logic [DIV_BITS-1:0] r_quot;

    logic [CNT_W-1:0] bit_idx;
    logic [17:0]      trial;
    logic             fits;

    assign bit_idx = CNT_W'(DIV_BITS - 1) - r_cnt;
    assign trial   = {r_rem, DIVIDEND[bit_idx]};
    assign fits    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? 17'(trial - {1'b0, r_den}) : trial[16:0];
                r_quot <= {r_quot[DIV_BITS-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/grid_raycast_column_core.sv =====
`default_nettype none

// Grid ray caster for one screen column.
// Input channel (i_in_valid / o_in_stall): a load word (command 0) writes one wall
// bit into the map and gives no result; a cast word (command 1) marches
// a ray from the camera and gives one result word.
// Output channel (o_out_valid / i_out_stall): hit flag, stop distance, wall face and
// the wall span rows. The result sits in an output register until taken; the core
// takes the next word meanwhile, but a second finished result waits behind it and
// stalls the input until the output register is free.
// A cast is one word at a time: angle reduction, sine/cosine lookup and step
// products on the shared multiplier, march setup, then one march probe at a time
// with a registered map read (plus a drain of that read), then the bit-serial
// wall-height divide on a hit, and the hand-off to the output register.
// Configuration is by APB: step_length at 0x0, range_limit at 0x4, to be written only
// idle by the user; the core does not enforce this. Reset (synchronous, active low)
// restores the register defaults and empties the output; the map is not cleared and must be loaded before casting.
module grid_raycast_column_core
    import grc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [9:0]  i_cell_index,
    input  wire logic        i_cell_is_wall,
    input  wire logic [14:0] i_camera_x,
    input  wire logic [14:0] i_camera_y,
    input  wire logic [8:0]  i_heading,
    input  wire logic [5:0]  i_column,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_wall_hit,
    output logic      [15:0] o_march_distance,
    output logic             o_wall_face,
    output logic      [4:0]  o_top_row,
    output logic      [5:0]  o_bottom_row
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANGLE,
        S_TRIG,
        S_MULC,
        S_MULS,
        S_INIT,
        S_MARCH,
        S_DIV
    } t_state;

    function automatic logic signed [17:0] trunc_prod(input logic signed [27:0] p);
        logic signed [27:0] t;
        t = p[27] ? p + 28'sd1023 : p;
        return t[27:10];
    endfunction

    function automatic logic signed [9:0] cell_tz(input logic signed [18:0] s);
        logic [18:0] mag;
        logic [9:0]  c;
        mag = s[18] ? 19'(-s) : 19'(s);
        c   = {1'b0, mag[18:10]};
        return s[18] ? -$signed(c) : $signed(c);
    endfunction

    t_state r_state;

    logic [7:0]  r_step;
    logic [15:0] r_range;

    logic [12:0]        r_angle;
    logic [14:0]        r_cx;
    logic [14:0]        r_cy;
    logic signed [11:0] r_sin;
    logic signed [11:0] r_cos;
    logic signed [20:0] r_cstep;
    logic signed [20:0] r_sstep;
    logic signed [27:0] r_acc_x;
    logic signed [27:0] r_acc_y;
    logic [16:0]        r_dist;
    logic signed [9:0]  r_prev_cell;

    logic               r_s1_valid;
    logic [16:0]        r_s1_dist;
    logic [8:0]         r_s1_cell;
    logic signed [9:0]  r_s1_prev;

    logic        r_hit;
    logic        r_face;
    logic [16:0] r_res_dist;
    logic        r_res_ready;
    logic [5:0]  r_span;

    logic        r_out_valid;
    logic        r_out_hit;
    logic [15:0] r_out_dist;
    logic        r_out_face;
    logic [4:0]  r_out_top;
    logic [5:0]  r_out_bottom;

    logic                  in_acc;
    logic                  cfg_wr;
    logic [12:0]           angle_raw;
    logic [8:0]            angle9;
    logic [8:0]            cos_angle;
    logic [8:0]            step_eff;
    logic signed [11:0]    mul_a;
    logic signed [20:0]    mul_p;
    logic signed [17:0]    tx;
    logic signed [17:0]    ty;
    logic signed [18:0]    sum_x;
    logic signed [18:0]    sum_y;
    logic                  out_map;
    logic [8:0]            cell_x;
    logic [8:0]            cell_y;
    logic [MAP_ADDR_W-1:0] probe_addr;
    logic signed [17:0]    t0;
    logic signed [18:0]    sum0;
    logic                  map_q;
    logic                  probe_hit;
    logic                  range_end;
    logic                  div_start;
    logic                  div_done;
    logic [DIV_BITS-1:0]   div_quot;
    logic [4:0]            half_span;
    logic                  out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_STEP_LENGTH: prdata = {24'd0, r_step};
            REG_RANGE_LIMIT: prdata = {16'd0, r_range};
            default:         prdata = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE) || r_res_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign angle_raw = 13'(i_heading) + 13'(ANGLE_BIAS) + col_offset(i_column);
    assign angle9    = r_angle[8:0];
    assign cos_angle = (angle9 >= 9'(FULL_TURN - QUARTER_TURN))
                     ? angle9 - 9'(FULL_TURN - QUARTER_TURN)
                     : angle9 + 9'(QUARTER_TURN);

    assign step_eff = (r_step == 8'd0) ? 9'd1 : {1'b0, r_step};
    assign mul_a    = (r_state == S_MULC) ? r_cos : r_sin;
    assign mul_p    = 21'(mul_a * $signed({1'b0, step_eff}));

    // current probe
    assign tx    = trunc_prod(r_acc_x);
    assign ty    = trunc_prod(r_acc_y);
    assign sum_x = $signed({4'd0, r_cx}) + $signed({tx[17], tx});
    assign sum_y = $signed({4'd0, r_cy}) + $signed({ty[17], ty});
    assign cell_x = sum_x[18] ? 9'd0 : sum_x[18:10];
    assign cell_y = sum_y[18] ? 9'd0 : sum_y[18:10];
    assign out_map = (sum_x <= -19'sd1024) || (sum_y <= -19'sd1024)
                  || (cell_x >= 9'(MAP_WIDTH)) || (cell_y >= 9'(MAP_HEIGHT));
    assign probe_addr = MAP_ADDR_W'(18'(cell_y) * 18'(MAP_WIDTH) + 18'(cell_x));
    assign range_end  = r_dist >= {1'b0, r_range};

    // cell x one step before the first probe
    assign t0   = trunc_prod(28'(r_cos) - 28'(r_cstep));
    assign sum0 = $signed({4'd0, r_cx}) + $signed({t0[17], t0});

    assign probe_hit = (r_state == S_MARCH) && r_s1_valid && map_q;
    assign div_start = probe_hit;

    assign half_span = r_span[5:1];
    assign out_free  = !r_out_valid || !i_out_stall;

    grc_map u_map (
        .i_clk   (i_clk),
        .i_we    (in_acc && (t_cmd'(i_command) == CMD_LOAD)),
        .i_waddr (i_cell_index),
        .i_wdata (i_cell_is_wall),
        .i_raddr (probe_addr),
        .o_rdata (map_q)
    );

    grc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_s1_dist + 17'd1),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 8'(STEP_RESET);
            r_range     <= 16'(RANGE_RESET);
            r_s1_valid  <= 1'b0;
            r_res_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[2]))
                    REG_STEP_LENGTH: r_step  <= pwdata[7:0];
                    REG_RANGE_LIMIT: r_range <= pwdata[15:0];
                    default: ;
                endcase
            end

            // finished cast waits here until the output register is free
            if (r_res_ready && out_free) begin
                r_res_ready  <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_hit    <= r_hit;
                r_out_dist   <= r_res_dist[16] ? 16'hFFFF : r_res_dist[15:0];
                r_out_face   <= r_face;
                r_out_top    <= 5'(ROW_CENTRE) - half_span;
                r_out_bottom <= 6'(ROW_CENTRE) + {1'b0, half_span};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (t_cmd'(i_command) == CMD_CAST)) begin
                        r_angle <= angle_raw;
                        r_cx    <= i_camera_x;
                        r_cy    <= i_camera_y;
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    if (r_angle >= 13'(FULL_TURN)) begin
                        r_angle <= r_angle - 13'(FULL_TURN);
                    end else begin
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    r_sin   <= rom_sin(angle9);
                    r_cos   <= rom_sin(cos_angle);
                    r_state <= S_MULC;
                end
                S_MULC: begin
                    r_cstep <= mul_p;
                    r_state <= S_MULS;
                end
                S_MULS: begin
                    r_sstep <= mul_p;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_acc_x     <= 28'(r_cos);
                    r_acc_y     <= 28'(r_sin);
                    r_dist      <= 17'd1;
                    r_prev_cell <= cell_tz(sum0);
                    r_s1_valid  <= 1'b0;
                    r_state     <= S_MARCH;
                end
                S_MARCH: begin
                    if (probe_hit) begin
                        r_hit      <= 1'b1;
                        r_face     <= (r_s1_prev != $signed({1'b0, r_s1_cell}));
                        r_res_dist <= r_s1_dist;
                        r_s1_valid <= 1'b0;
                        r_state    <= S_DIV;
                    end else if (range_end || out_map) begin
                        r_hit       <= 1'b0;
                        r_face      <= 1'b0;
                        r_res_dist  <= r_dist;
                        r_span      <= 6'd0;
                        r_s1_valid  <= 1'b0;
                        r_res_ready <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_s1_valid  <= 1'b1;
                        r_s1_dist   <= r_dist;
                        r_s1_cell   <= cell_x;
                        r_s1_prev   <= r_prev_cell;
                        r_prev_cell <= $signed({1'b0, cell_x});
                        r_dist      <= r_dist + 17'(step_eff);
                        r_acc_x     <= r_acc_x + 28'(r_cstep);
                        r_acc_y     <= r_acc_y + 28'(r_sstep);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_span      <= (div_quot > DIV_BITS'(MAX_SPAN))
                                     ? 6'(MAX_SPAN) : div_quot[5:0];
                        r_res_ready <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_wall_hit       = r_out_hit;
    assign o_march_distance = r_out_dist;
    assign o_wall_face      = r_out_face;
    assign o_top_row        = r_out_top;
    assign o_bottom_row     = r_out_bottom;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
    import grc_pkg::*;

    localparam int GRID_W       = 32;
    localparam int GRID_H       = 32;
    localparam int SCREEN_COLS  = 48;
    localparam int SETTLE       = 700;
    localparam int HOLD_CYCLES  = 3000;
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASE_WORDS  = 62;
    localparam int N_PHASE      = 8;
    localparam int SCRIPT_LEN   = 15;

    localparam int PHASE_STRIDE [N_PHASE] = '{1, 255, 0, 7, 100, 37, 64, 20};
    localparam int PHASE_RANGE  [N_PHASE] = '{1500, 65280, 900, 0, 1, 20000, 65535, 12288};

    localparam int SINE_Q [0:90] = '{
        0, 18, 36, 54, 71, 89, 107, 125, 143, 160,
        178, 195, 213, 230, 248, 265, 282, 299, 316, 333,
        350, 367, 384, 400, 416, 433, 449, 465, 481, 496,
        512, 527, 543, 558, 573, 587, 602, 616, 630, 644,
        658, 672, 685, 698, 711, 724, 737, 749, 761, 773,
        784, 796, 807, 818, 828, 839, 849, 859, 868, 878,
        887, 896, 904, 912, 920, 928, 935, 943, 949, 956,
        962, 968, 974, 979, 984, 989, 994, 998, 1002, 1005,
        1008, 1011, 1014, 1016, 1018, 1020, 1022, 1023, 1023, 1024,
        1024
    };

    typedef struct packed {
        t_cmd        cmd;
        logic [9:0]  cell_ix;
        logic        wall;
        logic [14:0] cam_x;
        logic [14:0] cam_y;
        logic [8:0]  heading;
        logic [5:0]  column;
    } ray_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] distance;
        logic        face;
        logic [4:0]  top;
        logic [5:0]  bottom;
    } ray_hit_t;

    typedef struct packed {
        ray_cmd_t word;
        logic     typed;
        ray_hit_t res;
    } script_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [9:0]  i_cell_index;
    logic        i_cell_is_wall;
    logic [14:0] i_camera_x;
    logic [14:0] i_camera_y;
    logic [8:0]  i_heading;
    logic [5:0]  i_column;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_wall_hit;
    logic [15:0] o_march_distance;
    logic        o_wall_face;
    logic [4:0]  o_top_row;
    logic [5:0]  o_bottom_row;

    grid_raycast_column_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bit          wall_map [1024];
    logic [7:0]  cfg_step;
    logic [15:0] cfg_range;
    ray_hit_t    ray_due [$];

    int unsigned mismatches;
    int unsigned loads_sent;
    int unsigned casts_sent;
    int unsigned rays_checked;
    int unsigned hits_seen;
    int unsigned holds_done;
    int          send_calm;
    int          take_calm;
    bit          hold_req;
    bit          hold_active;

    // directed words: extremes, camera inside a wall, leaving the map on either edge,
    // out-of-range heading and column
    script_row_t script [SCRIPT_LEN] = '{
        '{'{CMD_LOAD, 10'd165, 1'b1, 15'd0, 15'd0, 9'd0, 6'd0}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd5632, 15'd5632, 9'd0, 6'd0}, 1'b1,
          '{1'b1, 16'd1, 1'b0, 5'd1, 6'd39}},
        '{'{CMD_LOAD, 10'd96, 1'b0, 15'h7fff, 15'h7fff, 9'h1ff, 6'h3f}, 1'b0, '0},
        '{'{CMD_CAST, 10'h3ff, 1'b1, 15'd100, 15'd3584, 9'd210, 6'd0}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd32767, 15'd0, 9'd30, 6'd0}, 1'b1,
          '{1'b0, 16'd1, 1'b0, 5'd20, 6'd20}},
        '{'{CMD_LOAD, 10'd0, 1'b1, 15'd0, 15'd0, 9'd0, 6'd0}, 1'b0, '0},
        '{'{CMD_LOAD, 10'd1, 1'b0, 15'd0, 15'd0, 9'd0, 6'd0}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd1500, 15'd512, 9'd210, 6'd0}, 1'b0, '0},
        '{'{CMD_LOAD, 10'd1023, 1'b1, 15'd0, 15'd0, 9'd0, 6'd0}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd32767, 15'd32767, 9'd0, 6'd0}, 1'b1,
          '{1'b1, 16'd1, 1'b0, 5'd1, 6'd39}},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd16384, 15'd16384, 9'd511, 6'd63}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd0, 15'd32767, 9'd359, 6'd47}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd20000, 15'd9000, 9'd90, 6'd24}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd0, 15'd0, 9'd150, 6'd0}, 1'b0, '0},
        '{'{CMD_CAST, 10'd0, 1'b0, 15'd9300, 15'd25000, 9'd0, 6'd47}, 1'b0, '0}
    };

    function automatic longint sine_deg(input int a);
        a = a % 360;
        if (a <= 90) return SINE_Q[a];
        if (a <= 180) return SINE_Q[180 - a];
        if (a <= 270) return -SINE_Q[a - 180];
        return -SINE_Q[360 - a];
    endfunction

    function automatic ray_hit_t trace_ray(input ray_cmd_t w);
        ray_hit_t r;
        longint   cx, cy, sn, cs, d, stride, rx, ry, px, span;
        int       ang;
        r        = '0;
        r.top    = 5'd20;
        r.bottom = 6'd20;
        cx       = w.cam_x;
        cy       = w.cam_y;
        ang      = (int'(w.heading) + 330 + (int'(w.column) * 60) / SCREEN_COLS) % 360;
        sn       = sine_deg(ang);
        cs       = sine_deg(ang + 90);
        stride   = (cfg_step == 8'd0) ? 1 : longint'(cfg_step);
        for (d = 1; d < longint'(cfg_range); d += stride) begin
            rx = (cx + cs * d / 1024) / 1024;
            ry = (cy + sn * d / 1024) / 1024;
            if (rx < 0 || rx >= GRID_W || ry < 0 || ry >= GRID_H)
                break;
            if (wall_map[int'((ry * GRID_W + rx) & 1023)]) begin
                px     = (cx + cs * (d - stride) / 1024) / 1024;
                r.hit  = 1'b1;
                r.face = (px != rx);
                break;
            end
        end
        r.distance = (d > 65535) ? 16'hffff : 16'(d);
        if (r.hit) begin
            span = 30720 / (d + 1);
            if (span > 38)
                span = 38;
            r.top    = 5'(20 - span / 2);
            r.bottom = 6'(20 + span / 2);
        end
        return r;
    endfunction

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic ray_cmd_t random_word();
        ray_cmd_t w;
        w.cmd     = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_CAST;
        w.cell_ix = 10'($urandom);
        w.wall    = ($urandom_range(0, 2) == 0);
        w.cam_x   = 15'($urandom);
        w.cam_y   = 15'($urandom);
        w.heading = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
        w.column  = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 47));
        return w;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_STEP_LENGTH)
            cfg_step = val[7:0];
        else
            cfg_range = val[15:0];
        @(posedge i_clk);
    endtask

    task automatic send_word(input ray_cmd_t w, input logic typed, input ray_hit_t typed_res);
        int gap;
        gap = hold_active ? 0 : draw_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= w.cmd;
        i_cell_index   <= w.cell_ix;
        i_cell_is_wall <= w.wall;
        i_camera_x     <= w.cam_x;
        i_camera_y     <= w.cam_y;
        i_heading      <= w.heading;
        i_column       <= w.column;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (w.cmd == CMD_LOAD) begin
            wall_map[w.cell_ix] = w.wall;
            loads_sent++;
        end else begin
            ray_due.push_back(typed ? typed_res : trace_ray(w));
            casts_sent++;
        end
    endtask

    initial begin : stimulus
        ray_cmd_t w;
        int       i, p, n;
        bit       rim;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_LOAD;
        i_cell_index   <= '0;
        i_cell_is_wall <= 1'b0;
        i_camera_x     <= '0;
        i_camera_y     <= '0;
        i_heading      <= '0;
        i_column       <= '0;
        i_out_stall    <= 1'b0;
        cfg_step       = 8'd20;
        cfg_range      = 16'd12288;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // whole map first: sparse interior, patchy rim
        for (i = 0; i < 1024; i++) begin
            w         = random_word();
            w.cmd     = CMD_LOAD;
            w.cell_ix = 10'(i);
            rim       = (i < GRID_W) || (i >= 1024 - GRID_W) ||
                        (i % GRID_W == 0) || (i % GRID_W == GRID_W - 1);
            w.wall    = rim ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0);
            send_word(w, 1'b0, '0);
        end

        for (i = 0; i < SCRIPT_LEN; i++)
            send_word(script[i].word, script[i].typed, script[i].res);
        i_in_valid <= 1'b0;

        for (p = 0; p < N_PHASE; p++) begin
            while (ray_due.size() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
            write_reg(REG_STEP_LENGTH, 32'(PHASE_STRIDE[p]));
            write_reg(REG_RANGE_LIMIT, 32'(PHASE_RANGE[p]));
            if (p == N_PHASE - 1)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(), 1'b0, '0);
            i_in_valid <= 1'b0;
        end

        while (ray_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d map loads and %0d ray casts (%0d wall hits) over %0d register settings",
                 loads_sent, casts_sent, hits_seen, N_PHASE + 1);
        $display("%0d results checked, %0d long output hold-offs", rays_checked, holds_done);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : take_results
        ray_hit_t got, want;
        int       pause;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                holds_done++;
                pause = HOLD_CYCLES;
            end else begin
                pause = draw_wait(take_calm);
            end
            if (pause > 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            hold_active = 1'b0;
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = '{o_wall_hit, o_march_distance, o_wall_face, o_top_row, o_bottom_row};
            if (ray_due.size() == 0) begin
                $display("%0t: unexpected result word, hit %0b distance %0d",
                         $time, got.hit, got.distance);
                mismatches++;
            end else begin
                want = ray_due.pop_front();
                check_field("wall_hit", want.hit, got.hit);
                check_field("march_distance", want.distance, got.distance);
                check_field("wall_face", want.face, got.face);
                check_field("top_row", want.top, got.top);
                check_field("bottom_row", want.bottom, got.bottom);
                rays_checked++;
                if (got.hit)
                    hits_seen++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, ray_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule
